>>> rtl/core/rpd_pkg.sv
// Shared types, constants and decode functions for the rc packet receive decoder.
package rpd_pkg;

	localparam int unsigned NUM_BYTES = 10;
	localparam int unsigned Q_DEPTH   = 2;
	localparam int unsigned Q_AW      = $clog2(Q_DEPTH);

	typedef logic [NUM_BYTES-1:0][7:0] pkt_t;
	typedef logic [3:0][7:0] hop_tbl_t;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BIND = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_FAIL = 2'd3;

	// config register indexes
	localparam logic CFG_HOP_PERIOD  = 1'b0;
	localparam logic CFG_TRIM_ENABLE = 1'b1;

	localparam logic [7:0] CHK_BIAS  = 8'h55;
	localparam logic [7:0] BIND_MARK = 8'hAA;

	// element 0 is the rightmost entry
	localparam pkt_t SIG_PKT = {8'hEF, 8'h7D, 8'hF2, 8'h08, 8'h08,
		8'h20, 8'h1B, 8'h82, 8'h96, 8'hF9};
	localparam hop_tbl_t BASE_LO    = {8'h3A, 8'h2A, 8'h1A, 8'h0A};
	localparam hop_tbl_t BASE_MID   = {8'h22, 8'h42, 8'h0A, 8'h2A};
	localparam hop_tbl_t BASE_HI    = {8'h32, 8'h12, 8'h3A, 8'h1A};
	localparam hop_tbl_t FIXED_1E   = {8'h38, 8'h18, 8'h41, 8'h21};
	localparam hop_tbl_t FIXED_1F   = {8'h39, 8'h19, 8'h41, 8'h21};
	localparam hop_tbl_t RESET_HOPS = {8'h20, 8'h40, 8'h30, 8'h4B};

	localparam logic [4:0] ADDR_SKIP   = 5'h06;
	localparam logic [4:0] ADDR_MID    = 5'h10;
	localparam logic [4:0] ADDR_HI     = 5'h18;
	localparam logic [4:0] ADDR_BUMP   = 5'h16;
	localparam logic [4:0] ADDR_FIX_1E = 5'h1E;

	// flag word layout
	localparam int unsigned FL_VIDEO    = 0;
	localparam int unsigned FL_PICTURE  = 1;
	localparam int unsigned FL_FLIP     = 2;
	localparam int unsigned FL_HEADLESS = 3;
	localparam int unsigned FL_EXT      = 4;

	// one classified packet, as queued between front and back
	typedef struct packed {
		logic              chk_ok;
		logic              is_sig;
		logic              is_bind;
		logic [7:0]        throttle;
		logic signed [7:0] elevator;
		logic signed [7:0] rudder;
		logic signed [7:0] aileron;
		logic [4:0]        flags;
		hop_tbl_t          hops;
	} item_t;

	function automatic hop_tbl_t build_hops(input logic [7:0] addr);
		logic [4:0] low;
		hop_tbl_t   t;
		low = addr[4:0];
		t   = RESET_HOPS;
		if (low < ADDR_MID) begin
			if (low == ADDR_SKIP)
				low = ADDR_SKIP + 5'd1;
			for (int i = 0; i < 4; i++)
				t[i] = BASE_LO[i] + {3'b000, low};
		end else if (low < ADDR_HI) begin
			for (int i = 0; i < 4; i++)
				t[i] = BASE_MID[i] + {5'b00000, low[2:0]};
			if (low == ADDR_BUMP) begin
				t[0] = t[0] + 8'd1;
				t[1] = t[1] + 8'd1;
			end
		end else if (low < ADDR_FIX_1E) begin
			for (int i = 0; i < 4; i++)
				t[i] = BASE_HI[i] + {5'b00000, low[2:0]};
		end else if (low == ADDR_FIX_1E) begin
			t = FIXED_1E;
		end else begin
			t = FIXED_1F;
		end
		return t;
	endfunction

	// sign-magnitude stick plus optional 6-bit trim, clamped to +-127
	function automatic logic signed [7:0] stick_calc(input logic [7:0] s,
		input logic [7:0] trim, input logic add_trim);
		logic signed [8:0] v;
		logic signed [8:0] t;
		logic signed [8:0] sum;
		v = s[7] ? -$signed({2'b00, s[6:0]}) : $signed({2'b00, s[6:0]});
		t = trim[5] ? -$signed({4'b0000, trim[4:0]}) : $signed({4'b0000, trim[4:0]});
		sum = add_trim ? v + t : v;
		if (sum > 9'sd127)
			sum = 9'sd127;
		else if (sum < -9'sd127)
			sum = -9'sd127;
		return sum[7:0];
	endfunction

endpackage

>>> rtl/core/rpd_front.sv
// Front end: checks and classifies an incoming packet word into a queue item.
module rpd_front (
	input  rpd_pkg::pkt_t  pkt,
	input  logic           trim_en,
	output rpd_pkg::item_t item
);
	import rpd_pkg::*;

	logic [7:0] xsum;
	logic       headless;
	logic       ext;

	always_comb begin
		xsum = '0;
		for (int i = 0; i < NUM_BYTES - 1; i++)
			xsum = xsum ^ pkt[i];
		xsum = xsum + CHK_BIAS;
	end

	assign headless = pkt[7][7];
	assign ext = !headless && ((pkt[5][5:0] | pkt[6][5:0] | pkt[7][5:0]) != 6'd0);

	always_comb begin
		item.chk_ok   = (xsum == pkt[9]);
		item.is_sig   = (pkt == SIG_PKT);
		item.is_bind  = (pkt[5] == BIND_MARK) && (pkt[6] == BIND_MARK)
			&& (pkt[7] == BIND_MARK);
		item.throttle = pkt[0];
		item.elevator = stick_calc(pkt[1], pkt[5], ext && trim_en);
		item.rudder   = stick_calc(pkt[2], pkt[6], ext && trim_en);
		item.aileron  = stick_calc(pkt[3], pkt[7], ext && trim_en);
		item.flags    = '0;
		item.flags[FL_VIDEO]    = pkt[4][7];
		item.flags[FL_PICTURE]  = pkt[4][6];
		item.flags[FL_FLIP]     = pkt[6][6];
		item.flags[FL_HEADLESS] = headless;
		item.flags[FL_EXT]      = ext;
		// address byte 0 of the transmitter is packet byte 4
		item.hops     = build_hops(pkt[4]);
	end

endmodule

>>> rtl/core/rpd_queue.sv
// Short item queue between front and back ends.
module rpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rpd_pkg::item_t wr_item,
	output logic           full,
	output logic           not_empty,
	input  logic           pop,
	output rpd_pkg::item_t rd_item
);
	import rpd_pkg::*;

	item_t          mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full      = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");

endmodule

>>> rtl/core/rpd_back.sv
// Back end: link phase machine, hop sequencing and held control values.
module rpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  rpd_pkg::item_t    item,
	output logic              item_pop,
	input  logic [7:0]        hop_period,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [7:0]        throttle,
	output logic signed [7:0] elevator,
	output logic signed [7:0] rudder,
	output logic signed [7:0] aileron,
	output logic              video_on,
	output logic              picture_on,
	output logic              flip_on,
	output logic              headless_on,
	output logic              extended_rates,
	output logic [7:0]        rf_channel,
	output logic              bound
);
	import rpd_pkg::*;

	typedef enum logic [1:0] {
		PH_PREBIND = 2'd0,
		PH_BIND    = 2'd1,
		PH_WAIT    = 2'd2,
		PH_DATA    = 2'd3
	} phase_t;

	phase_t            phase_q;
	hop_tbl_t          hop_tbl_q;
	logic [1:0]        hop_idx_q;
	logic [7:0]        pkt_cnt_q;
	logic [7:0]        throttle_q;
	logic signed [7:0] elevator_q;
	logic signed [7:0] rudder_q;
	logic signed [7:0] aileron_q;
	logic [4:0]        flags_q;
	logic [1:0]        status_q;
	logic              out_valid_q;
	logic [7:0]        cnt_inc;

	// take the next item whenever the output register is free or draining
	assign item_pop = item_valid && (!out_valid_q || out_ready);
	assign cnt_inc  = pkt_cnt_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREBIND;
			hop_tbl_q   <= RESET_HOPS;
			hop_idx_q   <= '0;
			pkt_cnt_q   <= '0;
			throttle_q  <= '0;
			elevator_q  <= '0;
			rudder_q    <= '0;
			aileron_q   <= '0;
			flags_q     <= '0;
			status_q    <= ST_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			if (item_pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (item_pop) begin
				if (phase_q != PH_PREBIND && !item.chk_ok) begin
					status_q <= ST_FAIL;
				end else begin
					case (phase_q)
						PH_PREBIND: begin
							status_q <= ST_WAIT;
							if (item.is_sig) begin
								hop_idx_q <= '0;
								phase_q   <= PH_BIND;
							end
						end
						PH_BIND: begin
							if (item.is_bind) begin
								hop_tbl_q <= item.hops;
								hop_idx_q <= '0;
								phase_q   <= PH_WAIT;
								status_q  <= ST_BIND;
							end else begin
								status_q  <= ST_WAIT;
							end
						end
						PH_WAIT: begin
							status_q <= ST_WAIT;
							// first data packet only opens the data phase
							if (!item.is_bind) begin
								pkt_cnt_q <= 8'd1;
								phase_q   <= PH_DATA;
							end
						end
						PH_DATA: begin
							throttle_q <= item.throttle;
							elevator_q <= item.elevator;
							rudder_q   <= item.rudder;
							aileron_q  <= item.aileron;
							flags_q    <= item.flags;
							status_q   <= ST_OK;
							if (cnt_inc >= hop_period) begin
								pkt_cnt_q <= '0;
								hop_idx_q <= hop_idx_q + 2'd1;
							end else begin
								pkt_cnt_q <= cnt_inc;
							end
						end
						default: begin
							status_q <= ST_WAIT;
							phase_q  <= PH_PREBIND;
						end
					endcase
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign throttle       = throttle_q;
	assign elevator       = elevator_q;
	assign rudder         = rudder_q;
	assign aileron        = aileron_q;
	assign video_on       = flags_q[FL_VIDEO];
	assign picture_on     = flags_q[FL_PICTURE];
	assign flip_on        = flags_q[FL_FLIP];
	assign headless_on    = flags_q[FL_HEADLESS];
	assign extended_rates = flags_q[FL_EXT];
	assign rf_channel     = hop_tbl_q[hop_idx_q];
	assign bound          = (phase_q == PH_WAIT) || (phase_q == PH_DATA);

	a_bind_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_BIND |-> phase_q == PH_WAIT)
		else $error("bind status outside wait phase");
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OK |-> phase_q == PH_DATA)
		else $error("decoded status outside data phase");
	a_wait_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> hop_idx_q == 2'd0)
		else $error("hop index moved before data phase");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(status_q) && $stable(hop_idx_q))
		else $error("result changed while stalled");

endmodule

>>> rtl/core/rc_packet_receive_decoder.sv
// Top level of the rc packet receive decoder: config registers and front/queue/back.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+------------------------------------
//   in      | input     | in_valid/in_ready  | packet_byte_0 .. packet_byte_9
//   out     | output    | out_valid/out_ready| status, sticks, flags, rf_channel,
//           |           |                    | bound
//   cfg     | input     | cfg_we             | cfg_addr, cfg_wdata
//
// One word per cycle in and out while neither side stalls. A packet is
// checked and classified in the cycle it is taken, queued (two entries), and
// applied to the link state the cycle it leaves the queue; its result shows
// on the next cycle. The queue absorbs an output stall only until it is full,
// then in_ready drops. Reset (arst_n low) puts the link in prebind with the
// default hop table, hop_period 4 and trims enabled.
module rc_packet_receive_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        packet_byte_0,
	input  logic [7:0]        packet_byte_1,
	input  logic [7:0]        packet_byte_2,
	input  logic [7:0]        packet_byte_3,
	input  logic [7:0]        packet_byte_4,
	input  logic [7:0]        packet_byte_5,
	input  logic [7:0]        packet_byte_6,
	input  logic [7:0]        packet_byte_7,
	input  logic [7:0]        packet_byte_8,
	input  logic [7:0]        packet_byte_9,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [7:0]        throttle,
	output logic signed [7:0] elevator,
	output logic signed [7:0] rudder,
	output logic signed [7:0] aileron,
	output logic              video_on,
	output logic              picture_on,
	output logic              flip_on,
	output logic              headless_on,
	output logic              extended_rates,
	output logic [7:0]        rf_channel,
	output logic              bound
);
	import rpd_pkg::*;

	logic [7:0] hop_period_q;
	logic       trim_en_q;
	pkt_t       pkt;
	item_t      front_item;
	item_t      head_item;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;
	logic       push;

	// config registers, to be written only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_period_q <= 8'd4;
			trim_en_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_HOP_PERIOD:  hop_period_q <= cfg_wdata;
				CFG_TRIM_ENABLE: trim_en_q    <= cfg_wdata[0];
				default:         hop_period_q <= hop_period_q;
			endcase
		end
	end

	assign pkt = {packet_byte_9, packet_byte_8, packet_byte_7, packet_byte_6,
		packet_byte_5, packet_byte_4, packet_byte_3, packet_byte_2,
		packet_byte_1, packet_byte_0};

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	rpd_front u_front (
		.pkt     (pkt),
		.trim_en (trim_en_q),
		.item    (front_item)
	);

	rpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (front_item),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.rd_item   (head_item)
	);

	rpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (q_not_empty),
		.item           (head_item),
		.item_pop       (q_pop),
		.hop_period     (hop_period_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.throttle       (throttle),
		.elevator       (elevator),
		.rudder         (rudder),
		.aileron        (aileron),
		.video_on       (video_on),
		.picture_on     (picture_on),
		.flip_on        (flip_on),
		.headless_on    (headless_on),
		.extended_rates (extended_rates),
		.rf_channel     (rf_channel),
		.bound          (bound)
	);

endmodule

>>> dv/tb_rc_packet_receive_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for rc_packet_receive_decoder: link phases, decode, hops, stalls.
module tb_rc_packet_receive_decoder;
	import rpd_pkg::*;

	// byte 0 of the packet is element 0
	typedef logic [0:9][7:0] frame_t;

	typedef enum logic [1:0] {PH_PREBIND, PH_BIND, PH_WAIT, PH_DATA} link_phase_e;

	// one output word, in port order
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] throttle;
		logic [7:0] elevator;
		logic [7:0] rudder;
		logic [7:0] aileron;
		logic       video;
		logic       picture;
		logic       flip;
		logic       headless;
		logic       ext;
		logic [7:0] channel;
		logic       bound;
	} report_t;

	// radio constants
	localparam logic [7:0] SUM_BIAS = 8'h55;
	localparam logic [7:0] MARK     = 8'hAA;
	localparam frame_t SIGNATURE = {8'hF9, 8'h96, 8'h82, 8'h1B, 8'h20,
		8'h08, 8'h08, 8'hF2, 8'h7D, 8'hEF};
	localparam logic [0:3][7:0] HOPS_LO       = {8'h0A, 8'h1A, 8'h2A, 8'h3A};
	localparam logic [0:3][7:0] HOPS_MID      = {8'h2A, 8'h0A, 8'h42, 8'h22};
	localparam logic [0:3][7:0] HOPS_HI       = {8'h1A, 8'h3A, 8'h12, 8'h32};
	localparam logic [0:3][7:0] HOPS_1E       = {8'h21, 8'h41, 8'h18, 8'h38};
	localparam logic [0:3][7:0] HOPS_1F       = {8'h21, 8'h41, 8'h19, 8'h39};
	localparam logic [0:3][7:0] HOPS_AT_RESET = {8'h4B, 8'h30, 8'h40, 8'h20};
	localparam logic [0:3][7:0] STICK_EDGES   = {8'h00, 8'h7F, 8'h80, 8'hFF};

	// run shape
	localparam int N_SEGS       = 9;
	localparam int SEG_LEN      = 160;
	localparam int HOLD_AT      = 600;   // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES  = 120;
	localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
	// hop_period per segment: high then low forces "lowered below the counter";
	// zero means hop on every data word; segments 4 and 6 draw at random
	localparam logic [0:8][7:0] HOP_PLAN = {8'd255, 8'd1, 8'd0, 8'd7, 8'd0,
		8'd2, 8'd0, 8'd255, 8'd3};

	// Tracks the link state of the receiver and queues the word each packet
	// should produce; results are checked in order against that queue.
	class rc_link_tracker;
		report_t     due_reports[$];
		int          mismatches;
		logic [7:0]  hop_period;
		logic        trim_en;
		link_phase_e phase;
		logic [0:3][7:0] hops;
		logic [1:0]  hop_idx;
		logic [7:0]  pkt_count;
		logic [7:0]  thr;
		logic [7:0]  elev;
		logic [7:0]  rud;
		logic [7:0]  ail;
		logic [4:0]  flags;   // video, picture, flip, headless, ext from bit 0 up

		function new();
			mismatches = 0;
			hop_period = 8'd4;
			trim_en    = 1'b1;
			phase      = PH_PREBIND;
			hops       = HOPS_AT_RESET;
			hop_idx    = '0;
			pkt_count  = '0;
			thr        = '0;
			elev       = '0;
			rud        = '0;
			ail        = '0;
			flags      = '0;
		endfunction

		function void write_reg(logic idx, logic [7:0] val);
			if (idx == CFG_HOP_PERIOD)
				hop_period = val;
			else
				trim_en = val[0];
		endfunction

		function int pending();
			return due_reports.size();
		endfunction

		// hop channels from the low 5 address bits
		function void load_hops(logic [7:0] addr);
			logic [4:0] lo;
			int i;
			lo = addr[4:0];
			if (lo < 5'h10) begin
				if (lo == 5'h06)
					lo = 5'h07;   // 6 is never used
				for (i = 0; i < 4; i++)
					hops[i] = HOPS_LO[i] + {3'b000, lo};
			end else if (lo < 5'h18) begin
				for (i = 0; i < 4; i++)
					hops[i] = HOPS_MID[i] + {5'b00000, lo[2:0]};
				if (lo == 5'h16) begin
					hops[0] = hops[0] + 8'd1;
					hops[1] = hops[1] + 8'd1;
				end
			end else if (lo < 5'h1E) begin
				for (i = 0; i < 4; i++)
					hops[i] = HOPS_HI[i] + {5'b00000, lo[2:0]};
			end else if (lo == 5'h1E) begin
				hops = HOPS_1E;
			end else begin
				hops = HOPS_1F;
			end
		endfunction

		// sign-magnitude stick, optional sign-magnitude trim, saturate to +-127
		function logic [7:0] mix_stick(logic [7:0] s, logic [7:0] t, logic add_t);
			int v;
			int tv;
			v = int'(s[6:0]);
			if (s[7])
				v = -v;
			tv = int'(t[4:0]);
			if (t[5])
				tv = -tv;
			if (add_t)
				v = v + tv;
			if (v > 127)
				v = 127;
			else if (v < -127)
				v = -127;
			return v[7:0];
		endfunction

		function void take_packet(frame_t p);
			logic [7:0] sum;
			logic       is_bind;
			logic       headless;
			logic       ext;
			logic       add_t;
			logic [1:0] st;
			report_t    r;
			int         i;
			sum = p[0];
			for (i = 1; i < 9; i++)
				sum = sum ^ p[i];
			sum = sum + SUM_BIAS;
			is_bind = (p[5] == MARK) && (p[6] == MARK) && (p[7] == MARK);
			st = ST_WAIT;

			if (phase != PH_PREBIND && sum != p[9]) begin
				st = ST_FAIL;   // bad checksum: nothing moves
			end else begin
				case (phase)
					PH_PREBIND: begin
						if (p == SIGNATURE) begin
							hop_idx = '0;
							phase   = PH_BIND;
						end
					end
					PH_BIND: begin
						if (is_bind) begin
							// address is stored reversed, so byte 4 is the low byte
							load_hops(p[4]);
							hop_idx = '0;
							phase   = PH_WAIT;
							st      = ST_BIND;
						end
					end
					PH_WAIT: begin
						// first data word only opens the data phase
						if (!is_bind) begin
							pkt_count = 8'd1;
							phase     = PH_DATA;
						end
					end
					default: begin
						headless = p[7][7];
						ext = !headless && (((p[5] | p[6] | p[7]) & 8'h3F) != 8'h00);
						add_t = ext && trim_en;
						thr   = p[0];
						elev  = mix_stick(p[1], p[5], add_t);
						rud   = mix_stick(p[2], p[6], add_t);
						ail   = mix_stick(p[3], p[7], add_t);
						flags = {ext, headless, p[6][6], p[4][6], p[4][7]};
						pkt_count = pkt_count + 8'd1;
						if (pkt_count >= hop_period) begin
							pkt_count = '0;
							hop_idx   = hop_idx + 2'd1;
						end
						st = ST_OK;
					end
				endcase
			end

			r.status   = st;
			r.throttle = thr;
			r.elevator = elev;
			r.rudder   = rud;
			r.aileron  = ail;
			r.video    = flags[0];
			r.picture  = flags[1];
			r.flip     = flags[2];
			r.headless = flags[3];
			r.ext      = flags[4];
			r.channel  = hops[hop_idx];
			r.bound    = (phase == PH_WAIT) || (phase == PH_DATA);
			due_reports.push_back(r);
		endfunction

		function void check_field(string nm, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, nm, want, got);
			end
		endfunction

		function void compare_report(report_t got);
			report_t want;
			if (due_reports.size() == 0) begin
				mismatches++;
				$display("%0t: result word with none expected, status %h channel %h",
					$time, got.status, got.channel);
			end else begin
				want = due_reports.pop_front();
				check_field("status", 8'(want.status), 8'(got.status));
				check_field("throttle", want.throttle, got.throttle);
				check_field("elevator", want.elevator, got.elevator);
				check_field("rudder", want.rudder, got.rudder);
				check_field("aileron", want.aileron, got.aileron);
				check_field("video_on", 8'(want.video), 8'(got.video));
				check_field("picture_on", 8'(want.picture), 8'(got.picture));
				check_field("flip_on", 8'(want.flip), 8'(got.flip));
				check_field("headless_on", 8'(want.headless), 8'(got.headless));
				check_field("extended_rates", 8'(want.ext), 8'(got.ext));
				check_field("rf_channel", want.channel, got.channel);
				check_field("bound", 8'(want.bound), 8'(got.bound));
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_addr;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	frame_t     frame;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] status;
	logic [7:0] throttle;
	logic signed [7:0] elevator;
	logic signed [7:0] rudder;
	logic signed [7:0] aileron;
	logic       video_on;
	logic       picture_on;
	logic       flip_on;
	logic       headless_on;
	logic       extended_rates;
	logic [7:0] rf_channel;
	logic       bound;

	rc_link_tracker tracker = new();
	int  n_reports   = 0;
	int  idle_cycles = 0;
	bit  steady      = 1'b0;   // both sides stop idling while set

	rc_packet_receive_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.packet_byte_0  (frame[0]),
		.packet_byte_1  (frame[1]),
		.packet_byte_2  (frame[2]),
		.packet_byte_3  (frame[3]),
		.packet_byte_4  (frame[4]),
		.packet_byte_5  (frame[5]),
		.packet_byte_6  (frame[6]),
		.packet_byte_7  (frame[7]),
		.packet_byte_8  (frame[8]),
		.packet_byte_9  (frame[9]),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.throttle       (throttle),
		.elevator       (elevator),
		.rudder         (rudder),
		.aileron        (aileron),
		.video_on       (video_on),
		.picture_on     (picture_on),
		.flip_on        (flip_on),
		.headless_on    (headless_on),
		.extended_rates (extended_rates),
		.rf_channel     (rf_channel),
		.bound          (bound)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	function automatic frame_t seal(frame_t f);
		logic [7:0] s;
		s = f[0];
		for (int i = 1; i < 9; i++)
			s = s ^ f[i];
		f[9] = s + SUM_BIAS;
		return f;
	endfunction

	// sealed, then checksum broken by a nonzero flip pattern
	function automatic frame_t spoil(frame_t f);
		f = seal(f);
		f[9] = f[9] ^ 8'($urandom_range(1, 255));
		return f;
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		for (int i = 0; i < 10; i++)
			f[i] = 8'($urandom);
		return f;
	endfunction

	// data word with random content, biased toward the trim corners
	function automatic frame_t data_frame();
		frame_t f;
		int r;
		f = rand_frame();
		r = $urandom_range(0, 99);
		f[7][7] = ($urandom_range(0, 3) == 0);
		if (r < 20) begin
			// no trims: extended rates off
			f[5][5:0] = '0;
			f[6][5:0] = '0;
			f[7][5:0] = '0;
		end else if (r < 35) begin
			// stick edges with full trims: saturation
			for (int i = 1; i < 4; i++) begin
				f[i] = STICK_EDGES[$urandom_range(0, 3)];
				f[i + 4][4:0] = 5'h1F;
			end
		end else if (r < 40) begin
			// bind marker inside the data phase is still plain data
			f[5] = MARK;
			f[6] = MARK;
			f[7] = MARK;
		end
		if ($urandom_range(0, 99) < 8)
			return spoil(f);
		else
			return seal(f);
	endfunction

	// offer one word; it is noted at the edge that takes it
	task automatic send_frame(frame_t f);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		frame    = f;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		tracker.take_packet(f);
	endtask

	// stop offering and let every expected word come out
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.write_reg(idx, val);
	endtask

	// Walks the link from prebind to data, hitting each phase's corner cases,
	// then a few data words at the stick and trim extremes.
	task automatic run_directed();
		frame_t f;
		logic [4:0] lo;
		int k;
		int b;
		// prebind: anything but the exact signature is ignored, checksum unchecked
		send_frame('0);
		send_frame('1);
		f = SIGNATURE;
		k = $urandom_range(0, 9);
		b = $urandom_range(0, 7);
		f[k][b] = ~f[k][b];
		send_frame(f);
		send_frame(rand_frame());
		send_frame(SIGNATURE);

		// bind: near-miss marker, then bad checksum, then the real bind word
		f = rand_frame();
		f[5] = MARK;
		f[6] = MARK;
		f[7] = MARK ^ 8'h01;
		send_frame(seal(f));
		f[7] = MARK;
		send_frame(spoil(f));
		// address low bits: skipped channel, bumped mid table, the two fixed tables
		case ($urandom_range(0, 4))
			0: lo = 5'h06;
			1: lo = 5'h16;
			2: lo = 5'h1E;
			3: lo = 5'h1F;
			default: lo = 5'($urandom_range(0, 31));
		endcase
		f[4][4:0] = lo;
		send_frame(seal(f));

		// wait-first-data: bind words keep waiting, first good data opens data
		f = rand_frame();
		f[5] = MARK;
		f[6] = MARK;
		f[7] = MARK;
		send_frame(seal(f));
		f = rand_frame();
		f[5] = 8'h11;
		send_frame(spoil(f));
		send_frame(seal(f));

		// data: positive saturation, all flags but headless
		f = '0;
		f[0] = 8'hFF;
		f[1] = 8'h7F;
		f[2] = 8'h7F;
		f[3] = 8'h7F;
		f[4] = 8'hC0;
		f[5] = 8'h1F;
		f[6] = 8'h5F;
		f[7] = 8'h1F;
		send_frame(seal(f));
		// negative saturation
		f = '1;
		f[7] = 8'h3F;
		send_frame(seal(f));
		// negative zero sticks, no trims
		f = rand_frame();
		f[1] = 8'h80;
		f[2] = 8'h80;
		f[3] = 8'h80;
		f[5][5:0] = '0;
		f[6][5:0] = '0;
		f[7][5:0] = '0;
		send_frame(seal(f));
		// headless masks the trims
		f = rand_frame();
		f[5] = 8'h1F;
		f[7][7] = 1'b1;
		send_frame(seal(f));
		// negative-zero trim still turns extended rates on
		f = '0;
		f[5] = 8'h20;
		send_frame(seal(f));
		send_frame(spoil(data_frame()));
		f = rand_frame();
		f[5] = MARK;
		f[6] = MARK;
		f[7] = MARK;
		send_frame(seal(f));
	endtask

	// main sequence
	initial begin
		int seg;
		int n;
		logic [7:0] hp;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		frame     = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		// random data in segments, registers rewritten between them while idle
		for (seg = 0; seg < N_SEGS; seg++) begin
			settle();
			hp = (seg == 4 || seg == 6) ? 8'($urandom_range(1, 255)) : HOP_PLAN[seg];
			write_reg(CFG_HOP_PERIOD, hp);
			write_reg(CFG_TRIM_ENABLE, {7'd0, (seg % 2) == 0});
			for (n = 0; n < SEG_LEN; n++) begin
				if ($urandom_range(0, 59) == 0)
					steady = ~steady;
				send_frame(data_frame());
			end
			steady = 1'b0;
		end

		settle();
		repeat (16) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off so the input backs up
	initial begin
		int stall;
		bit held;
		out_ready = 1'b0;
		stall     = 0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && n_reports >= HOLD_AT) begin
				held      = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				stall     = pick_gap();
			end
		end
	end

	// every word taken on the output is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.compare_report({status, throttle, elevator, rudder, aileron,
				video_on, picture_on, flip_on, headless_on, extended_rates,
				rf_channel, bound});
			n_reports++;
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> rc_packet_receive_decoder.f
rtl/core/rpd_pkg.sv
rtl/core/rpd_front.sv
rtl/core/rpd_queue.sv
rtl/core/rpd_back.sv
rtl/core/rc_packet_receive_decoder.sv
dv/tb_rc_packet_receive_decoder.sv
